// File: rtl/core/pft_pkg.sv
package pft_pkg;

  // Field and register widths.
  localparam int unsigned CfgWidth   = 25;
  localparam int unsigned ItemWidth  = 32;
  localparam int unsigned PointWidth = 24;
  localparam int unsigned OfsWidth   = 25;
  localparam int unsigned CntWidth   = 26;

  // Saturation limits of the running counters.
  localparam logic [OfsWidth-1:0] OfsMax  = '1;
  localparam logic [CntWidth-1:0] EmitMax = '1;

  // Index entries added per triangle.
  localparam logic [CntWidth-1:0] TriVerts = CntWidth'(3);

  // Configuration register indexes.
  localparam logic [0:0] REG_POINT_COUNT = 1'b0;
  localparam logic [0:0] REG_INDEX_TOTAL = 1'b1;

  // Input item operations.
  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_VERTEX = 2'd1,
    OP_END    = 2'd2
  } op_e;

  // Result record kinds.
  typedef enum logic [1:0] {
    KIND_TRI      = 2'd0,
    KIND_FACE     = 2'd1,
    KIND_MESH_END = 2'd2
  } kind_e;

  // One result record.
  typedef struct packed {
    kind_e                 kind;
    logic [PointWidth-1:0] point_a;
    logic [PointWidth-1:0] point_b;
    logic [PointWidth-1:0] point_c;
    logic [PointWidth-1:0] offset_a;
    logic [PointWidth-1:0] offset_b;
    logic [PointWidth-1:0] offset_c;
    logic [CntWidth-1:0]   vertex_base;
    logic [CntWidth-1:0]   index_count;
    logic                  mesh_nonempty;
    logic                  last;
  } rec_t;

  // Status of the fan core, for checks at the top level.
  typedef struct packed {
    logic                face_active;
    logic [CntWidth-1:0] emitted;
  } core_stat_t;

endpackage

// File: rtl/core/pft_fan_core.sv
module pft_fan_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_idx_i,
  input  logic [pft_pkg::CfgWidth-1:0]    cfg_data_i,
  input  logic                            accept_i,
  input  pft_pkg::op_e                    op_i,
  input  logic signed [pft_pkg::ItemWidth-1:0] face_vertex_count_i,
  input  logic [pft_pkg::ItemWidth-1:0]   point_index_i,
  output logic [1:0]                      n_o,
  output pft_pkg::rec_t                   rec0_o,
  output pft_pkg::rec_t                   rec1_o,
  output pft_pkg::core_stat_t             stat_o
);
  import pft_pkg::*;

  logic [CfgWidth-1:0]  point_count_q, index_total_q;
  logic [OfsWidth-1:0]  vo_q, vo_d;
  logic [CntWidth-1:0]  eic_q, eic_d;
  logic [CntWidth-1:0]  cfs_q, cfs_d;
  logic                 active_q, active_d;
  logic [OfsWidth-1:0]  fsize_q, fsize_d;
  logic [OfsWidth-1:0]  pos_q, pos_d;
  logic [ItemWidth-1:0] ffp_q, ffp_d;
  logic [ItemWidth-1:0] fpp_q, fpp_d;

  // Offset sum clamped to the largest offset.
  function automatic logic [OfsWidth-1:0] sat_ofs(input logic [ItemWidth:0] s);
    logic [ItemWidth:0] lim;
    lim = {{(ItemWidth+1-OfsWidth){1'b0}}, OfsMax};
    return (s > lim) ? OfsMax : s[OfsWidth-1:0];
  endfunction

  // A point index is usable when it is non-negative and below the point count.
  function automatic logic point_ok(input logic [ItemWidth-1:0] p,
                                    input logic [CfgWidth-1:0]  pc);
    return !p[ItemWidth-1] && (p[ItemWidth-2:CfgWidth] == '0) && (p[CfgWidth-1:0] < pc);
  endfunction

  // Face record with the given start and index count.
  function automatic rec_t face_rec(input logic [CntWidth-1:0] start,
                                    input logic [CntWidth-1:0] cnt);
    rec_t r;
    r             = '0;
    r.kind        = KIND_FACE;
    r.vertex_base = start;
    r.index_count = cnt;
    return r;
  endfunction

  // Next state and up to two result records for the item on the input.
  always_comb begin
    logic [OfsWidth-1:0]  vo1;
    logic [CntWidth-1:0]  eic1;
    logic [OfsWidth-1:0]  pos1;
    logic [ItemWidth-1:0] cnt_pos;
    logic                 invalid;
    logic [CntWidth:0]    eic_sum;
    logic [ItemWidth:0]   vo_ext;
    rec_t                 r;
    vo_d     = vo_q;
    eic_d    = eic_q;
    cfs_d    = cfs_q;
    active_d = active_q;
    fsize_d  = fsize_q;
    pos_d    = pos_q;
    ffp_d    = ffp_q;
    fpp_d    = fpp_q;
    n_o      = 2'd0;
    rec0_o   = '0;
    rec1_o   = '0;
    vo1      = vo_q;
    eic1     = eic_q;
    pos1     = pos_q + OfsWidth'(1);
    cnt_pos  = face_vertex_count_i[ItemWidth-1] ? '0 : face_vertex_count_i;
    invalid  = 1'b0;
    eic_sum  = {1'b0, eic_q} + {1'b0, TriVerts};
    vo_ext   = '0;
    r        = '0;

    case (op_i)
      OP_HEADER: begin
        // Close the open face before the new header is taken.
        if (active_q) begin
          rec0_o = face_rec(cfs_q, eic_q - cfs_q);
          n_o    = 2'd1;
          vo1    = sat_ofs({{(ItemWidth+1-OfsWidth){1'b0}}, vo_q} +
                           {{(ItemWidth+1-OfsWidth){1'b0}}, fsize_q});
        end
        vo_ext  = {{(ItemWidth+1-OfsWidth){1'b0}}, vo1};
        invalid = (face_vertex_count_i < 32'sd3) ||
                  ((vo_ext + {1'b0, face_vertex_count_i}) >
                   {{(ItemWidth+1-CfgWidth){1'b0}}, index_total_q});
        if (invalid) begin
          r = face_rec(eic_q, '0);
          if (n_o == 2'd0) begin
            rec0_o = r;
          end else begin
            rec1_o = r;
          end
          n_o      = n_o + 2'd1;
          vo_d     = sat_ofs(vo_ext + {1'b0, cnt_pos});
          active_d = 1'b0;
        end else begin
          vo_d     = vo1;
          active_d = 1'b1;
          fsize_d  = face_vertex_count_i[OfsWidth-1:0];
          pos_d    = '0;
          cfs_d    = eic_q;
        end
      end
      OP_VERTEX: begin
        if (active_q) begin
          if (pos_q == '0) begin
            ffp_d = point_index_i;
          end else if ((pos_q >= OfsWidth'(2)) && point_ok(ffp_q, point_count_q) &&
                       point_ok(fpp_q, point_count_q) &&
                       point_ok(point_index_i, point_count_q)) begin
            // Emit the fan triangle and count its indices.
            rec0_o.kind        = KIND_TRI;
            rec0_o.point_a     = ffp_q[PointWidth-1:0];
            rec0_o.point_b     = fpp_q[PointWidth-1:0];
            rec0_o.point_c     = point_index_i[PointWidth-1:0];
            rec0_o.offset_a    = vo_q[PointWidth-1:0];
            rec0_o.offset_b    = PointWidth'(vo_q + pos_q - OfsWidth'(1));
            rec0_o.offset_c    = PointWidth'(vo_q + pos_q);
            rec0_o.vertex_base = eic_q;
            n_o                = 2'd1;
            eic1 = (eic_sum > {1'b0, EmitMax}) ? EmitMax : eic_sum[CntWidth-1:0];
          end
          fpp_d = point_index_i;
          pos_d = pos1;
          eic_d = eic1;
          // The face closes on its last declared vertex.
          if (pos1 >= fsize_q) begin
            r = face_rec(cfs_q, eic1 - cfs_q);
            if (n_o == 2'd0) begin
              rec0_o = r;
            end else begin
              rec1_o = r;
            end
            n_o      = n_o + 2'd1;
            vo_d     = sat_ofs({{(ItemWidth+1-OfsWidth){1'b0}}, vo_q} +
                               {{(ItemWidth+1-OfsWidth){1'b0}}, fsize_q});
            active_d = 1'b0;
          end
        end
      end
      OP_END: begin
        if (active_q) begin
          rec0_o = face_rec(cfs_q, eic_q - cfs_q);
          n_o    = 2'd1;
        end
        r               = '0;
        r.kind          = KIND_MESH_END;
        r.index_count   = eic_q;
        r.mesh_nonempty = (eic_q != '0);
        if (n_o == 2'd0) begin
          rec0_o = r;
        end else begin
          rec1_o = r;
        end
        n_o      = n_o + 2'd1;
        // Running counters start over for the next mesh.
        vo_d     = '0;
        eic_d    = '0;
        cfs_d    = '0;
        active_d = 1'b0;
        fsize_d  = '0;
        pos_d    = '0;
        ffp_d    = '0;
        fpp_d    = '0;
      end
      default: begin
      end
    endcase

    // Mark the final record of this item.
    if (n_o == 2'd1) begin
      rec0_o.last = 1'b1;
    end else if (n_o == 2'd2) begin
      rec1_o.last = 1'b1;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= '0;
      index_total_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POINT_COUNT: point_count_q <= cfg_data_i;
        REG_INDEX_TOTAL: index_total_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Mesh state advances on every accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q     <= '0;
      eic_q    <= '0;
      cfs_q    <= '0;
      active_q <= 1'b0;
      fsize_q  <= '0;
      pos_q    <= '0;
      ffp_q    <= '0;
      fpp_q    <= '0;
    end else if (accept_i) begin
      vo_q     <= vo_d;
      eic_q    <= eic_d;
      cfs_q    <= cfs_d;
      active_q <= active_d;
      fsize_q  <= fsize_d;
      pos_q    <= pos_d;
      ffp_q    <= ffp_d;
      fpp_q    <= fpp_d;
    end
  end

  assign stat_o.face_active = active_q;
  assign stat_o.emitted     = eic_q;

endmodule

// File: rtl/core/pft_out_buf.sv
module pft_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [1:0]    n_i,
  input  pft_pkg::rec_t rec0_i,
  input  pft_pkg::rec_t rec1_i,
  output logic          space_o,
  output logic          valid_o,
  input  logic          ready_i,
  output pft_pkg::rec_t rec_o
);
  import pft_pkg::*;

  rec_t       ent_q [3];
  rec_t       ent_d [3];
  logic [1:0] count_q, count_d;
  logic       pop;
  logic [1:0] rem;

  // One record leaves per transfer; an item enters when two slots are free.
  assign pop     = (count_q != 2'd0) && ready_i;
  assign rem     = count_q - {1'b0, pop};
  assign space_o = (rem < 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign rec_o   = ent_q[0];

  // Shift out the head, then append the new records behind what remains.
  always_comb begin
    ent_d   = ent_q;
    count_d = rem;
    if (pop) begin
      ent_d[0] = ent_q[1];
      ent_d[1] = ent_q[2];
    end
    if (push_i) begin
      if (!rem[0]) begin
        ent_d[0] = rec0_i;
        ent_d[1] = rec1_i;
      end else begin
        ent_d[1] = rec0_i;
        ent_d[2] = rec1_i;
      end
      count_d = rem + n_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// File: rtl/core/polygon_fan_triangulator.sv
// Polygon fan triangulator. Face headers, face vertices and end-of-mesh items
// enter on the slave stream; triangles, face records and mesh end records leave
// on the master stream as early as the cycle after the item is taken. One input
// item is taken per cycle while the queue has room; its fan state and results
// settle in the cycle of its transfer, and the records go into a three-entry
// output queue. An item that closes a face while also making a triangle, or
// closes an open face ahead of a header that is too short or overruns the index
// total, or ahead of the end of mesh, queues two records; the input takes an
// item whenever two queue slots are free after this cycle's output transfer.
// point_count and index_total reset to zero. The user writes them through the
// plain write port only while the stream is idle; the block does not enforce it.
module polygon_fan_triangulator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_idx_i,
  input  logic [pft_pkg::CfgWidth-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // face_vertex_count [31:0], point_index [63:32]
  input  logic [63:0]                  s_axis_tdata,
  // operation [1:0]
  input  logic [1:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // point_a [23:0], point_b [47:24], point_c [71:48], offset_a [95:72],
  // offset_b [119:96], offset_c [143:120], vertex_base [169:144],
  // index_count [195:170], mesh_nonempty [196], zero [199:197]
  output logic [199:0]                 m_axis_tdata,
  // kind [1:0]
  output logic [1:0]                   m_axis_tuser,
  output logic                         m_axis_tlast
);
  import pft_pkg::*;

  logic       accept;
  logic [1:0] n;
  rec_t       rec0, rec1, rec_out;
  core_stat_t core_stat;
  op_e        op;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign op     = op_e'(s_axis_tuser);

  // Fan state and record generation.
  pft_fan_core u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .accept_i            (accept),
    .op_i                (op),
    .face_vertex_count_i (s_axis_tdata[31:0]),
    .point_index_i       (s_axis_tdata[63:32]),
    .n_o                 (n),
    .rec0_o              (rec0),
    .rec1_o              (rec1),
    .stat_o              (core_stat)
  );

  // Output record queue.
  pft_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .n_i     (n),
    .rec0_i  (rec0),
    .rec1_i  (rec1),
    .space_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .rec_o   (rec_out)
  );

  // Pack the record onto the master stream.
  assign m_axis_tdata = {3'b000, rec_out.mesh_nonempty, rec_out.index_count,
                         rec_out.vertex_base, rec_out.offset_c, rec_out.offset_b,
                         rec_out.offset_a, rec_out.point_c, rec_out.point_b,
                         rec_out.point_a};
  assign m_axis_tuser = rec_out.kind;
  assign m_axis_tlast = rec_out.last;

  // An item that yields records has one on the output in the next cycle.
  a_result_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (n != 2'd0) |=> m_axis_tvalid)
    else $error("accepted item produced no visible record");

  // End of mesh leaves the running counters cleared.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op == OP_END) |=> (core_stat.emitted == '0) && !core_stat.face_active)
    else $error("mesh end did not clear the running state");

  // The unused kind code never leaves the block.
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("output record has an undefined kind");

endmodule

// File: dv/fan_record_checker.sv
`timescale 1ns / 100ps

// Watches both streams of the fan triangulator. Every accepted input transfer
// runs through a local fan model that queues the records it should cause, and
// every accepted output transfer is compared with the oldest queued record.
module fan_record_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_idx_i,
  input  logic [pft_pkg::CfgWidth-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [63:0]                  s_axis_tdata,
  input  logic [1:0]                   s_axis_tuser,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [199:0]                 m_axis_tdata,
  input  logic [1:0]                   m_axis_tuser,
  input  logic                         m_axis_tlast,
  output int unsigned                  mismatch_count_o,
  output int unsigned                  records_pending_o
);

  // A face needs at least this many vertices to make a triangle.
  localparam int MinFaceVerts = 3;
  localparam int unsigned ReportLimit = 10;

  // Register copies.
  logic [pft_pkg::CfgWidth-1:0] point_limit = '0;
  logic [pft_pkg::CfgWidth-1:0] index_limit = '0;

  // Fan state.
  logic [pft_pkg::OfsWidth-1:0] vtx_offset = '0;
  logic [pft_pkg::CntWidth-1:0] emitted = '0;
  logic [pft_pkg::CntWidth-1:0] face_start = '0;
  logic                         in_face = 1'b0;
  logic [pft_pkg::OfsWidth-1:0] face_len = '0;
  logic [pft_pkg::OfsWidth-1:0] face_pos = '0;
  logic [31:0]                  fan_first = '0;
  logic [31:0]                  fan_prev = '0;

  pft_pkg::rec_t expected_records[$];
  int unsigned   mismatches = 0;

  function automatic pft_pkg::rec_t make_record(
    pft_pkg::kind_e kind,
    logic [23:0] pa, logic [23:0] pb, logic [23:0] pc,
    logic [23:0] oa, logic [23:0] ob, logic [23:0] oc,
    logic [25:0] vb, logic [25:0] ic, logic ne
  );
    pft_pkg::rec_t r;
    r.kind          = kind;
    r.point_a       = pa;
    r.point_b       = pb;
    r.point_c       = pc;
    r.offset_a      = oa;
    r.offset_b      = ob;
    r.offset_c      = oc;
    r.vertex_base   = vb;
    r.index_count   = ic;
    r.mesh_nonempty = ne;
    r.last          = 1'b0;
    return r;
  endfunction

  function automatic string rec_text(pft_pkg::rec_t r);
    return $sformatf("kind %0d pts %0d/%0d/%0d ofs %0d/%0d/%0d base %0d cnt %0d ne %0d last %0d",
                     r.kind, r.point_a, r.point_b, r.point_c, r.offset_a, r.offset_b,
                     r.offset_c, r.vertex_base, r.index_count, r.mesh_nonempty, r.last);
  endfunction

  // A point index is usable when it is non-negative and below the point count.
  function automatic logic point_valid(logic [31:0] raw);
    return !raw[31] && (raw < 32'(point_limit));
  endfunction

  // The face-vertex offset saturates instead of wrapping.
  function automatic logic [pft_pkg::OfsWidth-1:0] offset_add(
    logic [pft_pkg::OfsWidth-1:0] a, longint b
  );
    longint sum;
    sum = longint'(a) + b;
    return (sum > longint'(pft_pkg::OfsMax)) ? pft_pkg::OfsMax : sum[pft_pkg::OfsWidth-1:0];
  endfunction

  // Appends one record at the tail of the expected queue.
  task automatic enqueue_record(pft_pkg::rec_t r);
    expected_records = {expected_records, r};
  endtask

  task automatic clear_fan();
    vtx_offset = '0;
    emitted    = '0;
    face_start = '0;
    in_face    = 1'b0;
    face_len   = '0;
    face_pos   = '0;
    fan_first  = '0;
    fan_prev   = '0;
  endtask

  // Closing a face reports its start and the index entries made for it.
  task automatic close_face();
    enqueue_record(make_record(pft_pkg::KIND_FACE, '0, '0, '0, '0, '0, '0,
                               face_start, emitted - face_start, 1'b0));
    vtx_offset = offset_add(vtx_offset, longint'(face_len));
    in_face    = 1'b0;
  endtask

  task automatic predict_item(logic [1:0] op, logic [31:0] vcount, logic [31:0] pidx);
    int unsigned        queued;
    logic signed [31:0] cnt;
    pft_pkg::rec_t      tail;
    queued = expected_records.size();
    cnt    = vcount;
    case (op)
      pft_pkg::OP_HEADER: begin
        if (in_face) close_face();
        // A short face or one running past the index total is reported empty.
        if (cnt < MinFaceVerts ||
            longint'(vtx_offset) + longint'(cnt) > longint'(index_limit)) begin
          enqueue_record(make_record(pft_pkg::KIND_FACE, '0, '0, '0, '0, '0, '0,
                                     emitted, '0, 1'b0));
          vtx_offset = offset_add(vtx_offset, (cnt > 0) ? longint'(cnt) : 64'sd0);
        end else begin
          in_face    = 1'b1;
          face_len   = cnt[pft_pkg::OfsWidth-1:0];
          face_pos   = '0;
          face_start = emitted;
        end
      end
      pft_pkg::OP_VERTEX: begin
        if (in_face) begin
          if (face_pos == 0) begin
            fan_first = pidx;
          end else if (face_pos >= 2 && point_valid(fan_first) && point_valid(fan_prev) &&
                       point_valid(pidx)) begin
            enqueue_record(make_record(pft_pkg::KIND_TRI,
                                       fan_first[23:0], fan_prev[23:0], pidx[23:0],
                                       vtx_offset[23:0],
                                       24'(vtx_offset + face_pos - 25'd1),
                                       24'(vtx_offset + face_pos),
                                       emitted, '0, 1'b0));
            emitted = (emitted > pft_pkg::EmitMax - pft_pkg::TriVerts) ?
                      pft_pkg::EmitMax : emitted + pft_pkg::TriVerts;
          end
          fan_prev = pidx;
          face_pos = face_pos + 25'd1;
          if (face_pos >= face_len) close_face();
        end
      end
      pft_pkg::OP_END: begin
        if (in_face) close_face();
        enqueue_record(make_record(pft_pkg::KIND_MESH_END, '0, '0, '0, '0, '0, '0,
                                   '0, emitted, emitted != '0));
        clear_fan();
      end
      default: ;
    endcase
    // The final record caused by an item carries the last flag.
    if (expected_records.size() > queued) begin
      tail      = expected_records[expected_records.size() - 1];
      tail.last = 1'b1;
      expected_records[expected_records.size() - 1] = tail;
    end
  endtask

  task automatic check_record();
    pft_pkg::rec_t seen;
    pft_pkg::rec_t want;
    seen.kind          = pft_pkg::kind_e'(m_axis_tuser);
    seen.point_a       = m_axis_tdata[23:0];
    seen.point_b       = m_axis_tdata[47:24];
    seen.point_c       = m_axis_tdata[71:48];
    seen.offset_a      = m_axis_tdata[95:72];
    seen.offset_b      = m_axis_tdata[119:96];
    seen.offset_c      = m_axis_tdata[143:120];
    seen.vertex_base   = m_axis_tdata[169:144];
    seen.index_count   = m_axis_tdata[195:170];
    seen.mesh_nonempty = m_axis_tdata[196];
    seen.last          = m_axis_tlast;
    if (expected_records.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("%0t: unexpected record: %s", $realtime, rec_text(seen));
    end else begin
      want = expected_records.pop_front();
      if (seen !== want) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("%0t: record mismatch", $realtime);
          $display("  expected %s", rec_text(want));
          $display("  actual   %s", rec_text(seen));
        end
      end
    end
  endtask

  // Register writes, input transfers and output transfers, in edge order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_limit = '0;
      index_limit = '0;
      clear_fan();
      expected_records.delete();
      mismatch_count_o  <= 0;
      records_pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == pft_pkg::REG_POINT_COUNT) point_limit = cfg_data_i;
        else index_limit = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_item(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
      if (m_axis_tvalid && m_axis_tready) check_record();
      mismatch_count_o  <= mismatches;
      records_pending_o <= expected_records.size();
    end
  end

endmodule

// File: dv/tb_polygon_fan_triangulator.sv
`timescale 1ns / 100ps

module tb_polygon_fan_triangulator;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [1:0]  OpUnused   = 2'd3;
  // Largest point count and index total.
  localparam logic [pft_pkg::CfgWidth-1:0] CfgMax = 25'h1000000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [0:0]                   cfg_idx_i = '0;
  logic [pft_pkg::CfgWidth-1:0] cfg_data_i = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [63:0]                  s_axis_tdata = '0;
  logic [1:0]                   s_axis_tuser = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [199:0]                 m_axis_tdata;
  logic [1:0]                   m_axis_tuser;
  logic                         m_axis_tlast;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count;
  int unsigned records_pending;

  polygon_fan_triangulator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  fan_record_checker record_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .m_axis_tlast     (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .records_pending_o(records_pending)
  );

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The receiver stalls at random.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Writes both registers on consecutive cycles.
  task automatic write_config(logic [pft_pkg::CfgWidth-1:0] points,
                              logic [pft_pkg::CfgWidth-1:0] total);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= pft_pkg::REG_POINT_COUNT;
    cfg_data_i <= points;
    @(posedge clk_i);
    cfg_idx_i  <= pft_pkg::REG_INDEX_TOTAL;
    cfg_data_i <= total;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Offers one item after a random gap and returns at the edge of its transfer.
  task automatic send_item(logic [1:0] op, logic [31:0] vcount, logic [31:0] pidx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {pidx, vcount};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Holds the input idle until every expected record is out and the block is quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (records_pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly in-range point indices, with negative and out-of-range ones mixed in.
  function automatic logic [31:0] pick_point(int unsigned points);
    case ($urandom_range(19))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF;
      2:       return points;
      default: return (points == 0) ? $urandom_range(15) : $urandom_range(points - 1);
    endcase
  endfunction

  // Random meshes: mostly well-formed faces with random points, plus short or
  // overlong headers, truncated faces, stray vertices, mesh ends and unused codes.
  task automatic random_mesh(int unsigned points, int unsigned n_items);
    int unsigned sent;
    int unsigned sel;
    int unsigned face_verts;
    int unsigned verts_sent;
    logic [31:0] bad_count;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        case ($urandom_range(4))
          0:       bad_count = $urandom_range(2);
          1:       bad_count = {1'b1, 31'($urandom)};
          2:       bad_count = $urandom;
          3:       bad_count = 32'h7FFF_FFFF;
          default: bad_count = $urandom_range(100, 600);
        endcase
        send_item(pft_pkg::OP_HEADER, bad_count, $urandom);
        sent++;
        if ($urandom_range(1) == 1) begin
          send_item(pft_pkg::OP_VERTEX, $urandom, pick_point(points));
          sent++;
        end
      end else if (sel < 13) begin
        send_item(pft_pkg::OP_END, $urandom, $urandom);
        sent++;
      end else if (sel < 15) begin
        send_item(OpUnused, $urandom, $urandom);
        sent++;
      end else begin
        face_verts = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(3, 6);
        verts_sent = ($urandom_range(9) == 0) ? $urandom_range(face_verts - 1) : face_verts;
        send_item(pft_pkg::OP_HEADER, face_verts, $urandom);
        sent++;
        repeat (verts_sent) begin
          send_item(pft_pkg::OP_VERTEX, $urandom, pick_point(points));
          sent++;
        end
      end
    end
  endtask

  initial begin
    int unsigned points;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: small mesh with ten points and a total of forty indices.
    write_config(25'd10, 25'd40);
    send_item(pft_pkg::OP_VERTEX, 32'd0, 32'd5);              // no face open
    send_item(OpUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF);        // unused code
    send_item(pft_pkg::OP_HEADER, 32'd4, 32'd0);
    send_item(pft_pkg::OP_VERTEX, 32'd0, 32'd0);
    send_item(pft_pkg::OP_VERTEX, 32'd0, 32'd1);
    send_item(pft_pkg::OP_VERTEX, 32'd0, 32'd2);
    send_item(pft_pkg::OP_VERTEX, 32'd0, 32'd9);              // triangle and face close
    send_item(pft_pkg::OP_HEADER, 32'd4, 32'd0);
    send_item(pft_pkg::OP_VERTEX, 32'd0, 32'd0);
    send_item(pft_pkg::OP_VERTEX, 32'd0, 32'hFFFF_FFFF);      // negative point
    send_item(pft_pkg::OP_VERTEX, 32'd0, 32'd3);
    send_item(pft_pkg::OP_VERTEX, 32'd0, 32'd10);             // point at the count
    send_item(pft_pkg::OP_HEADER, 32'd5, 32'd0);
    send_item(pft_pkg::OP_VERTEX, 32'd0, 32'd1);
    send_item(pft_pkg::OP_VERTEX, 32'd0, 32'd2);
    send_item(pft_pkg::OP_HEADER, 32'd2, 32'd0);              // closes open face, too short
    send_item(pft_pkg::OP_HEADER, 32'h8000_0000, 32'd0);      // most negative count
    send_item(pft_pkg::OP_HEADER, 32'd30, 32'd0);             // runs past the total
    send_item(pft_pkg::OP_END, 32'd0, 32'd0);
    send_item(pft_pkg::OP_END, 32'd0, 32'd0);                 // empty mesh
    settle();

    // Directed: largest counts, offsets near the top and offset saturation.
    write_config(CfgMax, CfgMax);
    send_item(pft_pkg::OP_HEADER, 32'd16777200, 32'd0);
    send_item(pft_pkg::OP_VERTEX, 32'd0, 32'h00FF_FFFF);
    send_item(pft_pkg::OP_VERTEX, 32'd0, 32'd0);
    send_item(pft_pkg::OP_VERTEX, 32'd0, 32'd1);
    send_item(pft_pkg::OP_HEADER, 32'd4, 32'd0);              // closes the large face
    send_item(pft_pkg::OP_VERTEX, 32'd0, 32'd5);
    send_item(pft_pkg::OP_VERTEX, 32'd0, 32'd6);
    send_item(pft_pkg::OP_VERTEX, 32'd0, 32'd7);
    send_item(pft_pkg::OP_VERTEX, 32'd0, 32'd8);
    send_item(pft_pkg::OP_HEADER, 32'h7FFF_FFFF, 32'd0);      // offset saturates
    send_item(pft_pkg::OP_END, 32'd0, 32'd0);
    settle();

    // Random phases under three idling patterns, each with several settings.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      points = $urandom_range(4, 24);
      write_config(pft_pkg::CfgWidth'(points), CfgMax);
      random_mesh(points, 90);
      settle();
      write_config(CfgMax, pft_pkg::CfgWidth'($urandom_range(20, 80)));
      random_mesh(CfgMax, 70);
      settle();
      write_config('0, '0);
      random_mesh(0, 20);
      settle();
      points = $urandom_range(2, 12);
      write_config(pft_pkg::CfgWidth'(points), pft_pkg::CfgWidth'($urandom_range(100, 400)));
      random_mesh(points, 80);
      settle();
    end

    if (mismatch_count == 0 && records_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pft_pkg.sv
rtl/core/pft_fan_core.sv
rtl/core/pft_out_buf.sv
rtl/core/polygon_fan_triangulator.sv
dv/fan_record_checker.sv
dv/tb_polygon_fan_triangulator.sv
